[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, disabled in reset
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

[design/psimd_pkg.sv]
// Package: opcodes, payload types and saturation helpers for the SIMD ALU
package psimd_pkg;

   localparam int OpWidth = 6;

   typedef enum logic [OpWidth-1:0] {
      OP_AND = 6'd0, OP_ANDN = 6'd1, OP_OR = 6'd2, OP_XOR = 6'd3,
      OP_ADDB = 6'd4, OP_ADDW = 6'd5, OP_ADDD = 6'd6, OP_ADDQ = 6'd7,
      OP_SUBB = 6'd8, OP_SUBW = 6'd9, OP_SUBD = 6'd10, OP_SUBQ = 6'd11,
      OP_MULUDQ = 6'd12,
      OP_EQB = 6'd13, OP_EQW = 6'd14, OP_EQD = 6'd15,
      OP_GTB = 6'd16, OP_GTW = 6'd17, OP_GTD = 6'd18,
      OP_MAXUB = 6'd19, OP_MINUB = 6'd20, OP_MAXSW = 6'd21, OP_MINSW = 6'd22,
      OP_SRLW = 6'd23, OP_SRAW = 6'd24, OP_SLLW = 6'd25,
      OP_SRLD = 6'd26, OP_SRAD = 6'd27, OP_SLLD = 6'd28,
      OP_SRLQ = 6'd29, OP_SLLQ = 6'd30, OP_SRLDQ = 6'd31, OP_SLLDQ = 6'd32,
      OP_SHUFD = 6'd33, OP_SHUFLW = 6'd34, OP_SHUFHW = 6'd35,
      OP_UNPHB = 6'd36, OP_UNPHW = 6'd37, OP_UNPHD = 6'd38, OP_UNPHQ = 6'd39,
      OP_UNPLB = 6'd40, OP_UNPLW = 6'd41, OP_UNPLD = 6'd42, OP_UNPLQ = 6'd43,
      OP_PACKSSWB = 6'd44, OP_PACKSSDW = 6'd45, OP_PACKUSWB = 6'd46,
      OP_EXTRW = 6'd47, OP_INSRW = 6'd48, OP_MOVMSKB = 6'd49
   } opcode_type;

   typedef struct packed {
      logic [OpWidth-1:0] opcode;
      logic [63:0]        dst_lo;
      logic [63:0]        dst_hi;
      logic [63:0]        src_lo;
      logic [63:0]        src_hi;
      logic [7:0]         immediate;
      logic               count_from_imm;
   } req_type;

   typedef struct packed {
      logic [63:0] result_lo;
      logic [63:0] result_hi;
      logic        to_general_reg;
   } rsp_type;

   // Signed word to signed byte with saturation
   function automatic logic [7:0] sat_sb(input logic [15:0] v);
      logic signed [15:0] s;
      s = signed'(v);
      if (s < -16'sd128) return 8'h80;
      if (s > 16'sd127) return 8'h7f;
      return v[7:0];
   endfunction

   // Signed dword to signed word with saturation
   function automatic logic [15:0] sat_sw(input logic [31:0] v);
      logic signed [31:0] s;
      s = signed'(v);
      if (s < -32'sd32768) return 16'h8000;
      if (s > 32'sd32767) return 16'h7fff;
      return v[15:0];
   endfunction

   // Signed word to unsigned byte with saturation
   function automatic logic [7:0] sat_ub(input logic [15:0] v);
      if (v[15]) return 8'h00;
      if (v > 16'h00ff) return 8'hff;
      return v[7:0];
   endfunction

endpackage

[design/psimd_exec.sv]
// Combinational execute logic: one packed-integer operation on 128-bit operands
module psimd_exec import psimd_pkg::*; (
   input  req_type op_in,
   output rsp_type res_out
);

   logic [127:0] d, s, r;
   logic [63:0]  cnt;
   logic [7:0]   imm;
   logic [63:0]  rlo, rhi;
   logic         gen;
   logic [2:0]   widx;

   assign d    = {op_in.dst_hi, op_in.dst_lo};
   assign s    = {op_in.src_hi, op_in.src_lo};
   assign imm  = op_in.immediate;
   assign widx = imm[2:0];
   assign cnt  = op_in.count_from_imm ? {56'd0, imm} : op_in.src_lo;

   always_comb begin
      r   = '0;
      rlo = '0;
      rhi = '0;
      gen = 1'b0;
      unique case (op_in.opcode)
         OP_AND:  r = d & s;
         OP_ANDN: r = ~d & s;
         OP_OR:   r = d | s;
         OP_XOR:  r = d ^ s;
         OP_ADDB: for (int i = 0; i < 16; i++) r[i*8 +: 8] = d[i*8 +: 8] + s[i*8 +: 8];
         OP_ADDW: for (int i = 0; i < 8; i++) r[i*16 +: 16] = d[i*16 +: 16] + s[i*16 +: 16];
         OP_ADDD: for (int i = 0; i < 4; i++) r[i*32 +: 32] = d[i*32 +: 32] + s[i*32 +: 32];
         OP_ADDQ: for (int i = 0; i < 2; i++) r[i*64 +: 64] = d[i*64 +: 64] + s[i*64 +: 64];
         OP_SUBB: for (int i = 0; i < 16; i++) r[i*8 +: 8] = d[i*8 +: 8] - s[i*8 +: 8];
         OP_SUBW: for (int i = 0; i < 8; i++) r[i*16 +: 16] = d[i*16 +: 16] - s[i*16 +: 16];
         OP_SUBD: for (int i = 0; i < 4; i++) r[i*32 +: 32] = d[i*32 +: 32] - s[i*32 +: 32];
         OP_SUBQ: for (int i = 0; i < 2; i++) r[i*64 +: 64] = d[i*64 +: 64] - s[i*64 +: 64];
         OP_MULUDQ: for (int i = 0; i < 2; i++)
            r[i*64 +: 64] = 64'(d[i*64 +: 32]) * 64'(s[i*64 +: 32]);
         OP_EQB: for (int i = 0; i < 16; i++) r[i*8 +: 8] = {8{d[i*8 +: 8] == s[i*8 +: 8]}};
         OP_EQW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = {16{d[i*16 +: 16] == s[i*16 +: 16]}};
         OP_EQD: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = {32{d[i*32 +: 32] == s[i*32 +: 32]}};
         OP_GTB: for (int i = 0; i < 16; i++)
            r[i*8 +: 8] = {8{signed'(d[i*8 +: 8]) > signed'(s[i*8 +: 8])}};
         OP_GTW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = {16{signed'(d[i*16 +: 16]) > signed'(s[i*16 +: 16])}};
         OP_GTD: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = {32{signed'(d[i*32 +: 32]) > signed'(s[i*32 +: 32])}};
         OP_MAXUB: for (int i = 0; i < 16; i++)
            r[i*8 +: 8] = (d[i*8 +: 8] > s[i*8 +: 8]) ? d[i*8 +: 8] : s[i*8 +: 8];
         OP_MINUB: for (int i = 0; i < 16; i++)
            r[i*8 +: 8] = (d[i*8 +: 8] < s[i*8 +: 8]) ? d[i*8 +: 8] : s[i*8 +: 8];
         OP_MAXSW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = (signed'(d[i*16 +: 16]) > signed'(s[i*16 +: 16]))
                            ? d[i*16 +: 16] : s[i*16 +: 16];
         OP_MINSW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = (signed'(d[i*16 +: 16]) < signed'(s[i*16 +: 16]))
                            ? d[i*16 +: 16] : s[i*16 +: 16];
         // Lane shifts: out-of-range counts clear or sign-fill the lane
         OP_SRLW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = (cnt > 64'd15) ? '0 : d[i*16 +: 16] >> cnt[3:0];
         OP_SRAW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = 16'(signed'(d[i*16 +: 16]) >>>
                            ((cnt > 64'd15) ? 4'd15 : cnt[3:0]));
         OP_SLLW: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = (cnt > 64'd15) ? '0 : d[i*16 +: 16] << cnt[3:0];
         OP_SRLD: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = (cnt > 64'd31) ? '0 : d[i*32 +: 32] >> cnt[4:0];
         OP_SRAD: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = 32'(signed'(d[i*32 +: 32]) >>>
                            ((cnt > 64'd31) ? 5'd31 : cnt[4:0]));
         OP_SLLD: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = (cnt > 64'd31) ? '0 : d[i*32 +: 32] << cnt[4:0];
         OP_SRLQ: for (int i = 0; i < 2; i++)
            r[i*64 +: 64] = (cnt > 64'd63) ? '0 : d[i*64 +: 64] >> cnt[5:0];
         OP_SLLQ: for (int i = 0; i < 2; i++)
            r[i*64 +: 64] = (cnt > 64'd63) ? '0 : d[i*64 +: 64] << cnt[5:0];
         // Whole-register byte shifts, always by the immediate
         OP_SRLDQ: r = (imm > 8'd15) ? '0 : d >> {imm[3:0], 3'b000};
         OP_SLLDQ: r = (imm > 8'd15) ? '0 : d << {imm[3:0], 3'b000};
         OP_SHUFD: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = s[imm[i*2 +: 2]*32 +: 32];
         OP_SHUFLW: begin
            r = s;
            for (int i = 0; i < 4; i++) r[i*16 +: 16] = s[imm[i*2 +: 2]*16 +: 16];
         end
         OP_SHUFHW: begin
            r = s;
            for (int i = 0; i < 4; i++)
               r[64 + i*16 +: 16] = s[64 + imm[i*2 +: 2]*16 +: 16];
         end
         OP_UNPHB: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = {s[64 + i*8 +: 8], d[64 + i*8 +: 8]};
         OP_UNPHW: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = {s[64 + i*16 +: 16], d[64 + i*16 +: 16]};
         OP_UNPHD: for (int i = 0; i < 2; i++)
            r[i*64 +: 64] = {s[64 + i*32 +: 32], d[64 + i*32 +: 32]};
         OP_UNPHQ: r = {s[127:64], d[127:64]};
         OP_UNPLB: for (int i = 0; i < 8; i++)
            r[i*16 +: 16] = {s[i*8 +: 8], d[i*8 +: 8]};
         OP_UNPLW: for (int i = 0; i < 4; i++)
            r[i*32 +: 32] = {s[i*16 +: 16], d[i*16 +: 16]};
         OP_UNPLD: for (int i = 0; i < 2; i++)
            r[i*64 +: 64] = {s[i*32 +: 32], d[i*32 +: 32]};
         OP_UNPLQ: r = {s[63:0], d[63:0]};
         OP_PACKSSWB: for (int i = 0; i < 8; i++) begin
            r[i*8 +: 8]      = sat_sb(d[i*16 +: 16]);
            r[64 + i*8 +: 8] = sat_sb(s[i*16 +: 16]);
         end
         OP_PACKUSWB: for (int i = 0; i < 8; i++) begin
            r[i*8 +: 8]      = sat_ub(d[i*16 +: 16]);
            r[64 + i*8 +: 8] = sat_ub(s[i*16 +: 16]);
         end
         OP_PACKSSDW: for (int i = 0; i < 4; i++) begin
            r[i*16 +: 16]      = sat_sw(d[i*32 +: 32]);
            r[64 + i*16 +: 16] = sat_sw(s[i*32 +: 32]);
         end
         OP_EXTRW: begin
            r   = {112'd0, s[widx*16 +: 16]};
            gen = 1'b1;
         end
         OP_INSRW: begin
            r = d;
            r[widx*16 +: 16] = s[15:0];
         end
         OP_MOVMSKB: begin
            for (int i = 0; i < 16; i++) r[i] = s[i*8 + 7];
            gen = 1'b1;
         end
         default: r = '0;
      endcase
      rlo = r[63:0];
      rhi = r[127:64];
   end

   assign res_out = '{result_lo: rlo, result_hi: rhi, to_general_reg: gen};

endmodule

[design/packed_integer_simd_alu.sv]
// Top level: packed-integer SIMD ALU with input and result registers
// The input register captures an accepted request; its result, formed
// combinationally, is captured in the result register that drives rsp_valid.
// Throughput: one transaction per cycle; the result drains while the next
// executes, stalling only when both stages are full and rsp_ready is low.
// Reset: synchronous, active high; clears both stage valid flags.
module packed_integer_simd_alu import psimd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   req_type op_ff;
   logic    op_vld_ff, op_vld_in;
   rsp_type res_ff;
   logic    res_vld_ff, res_vld_in;
   rsp_type res_in;
   logic    adv;

   psimd_exec u_exec (.op_in(op_ff), .res_out(res_in));

   // Stage advance when the result register is free or being drained
   assign adv        = !res_vld_ff || rsp_ready;
   assign req_ready  = !op_vld_ff || adv;
   assign res_vld_in = adv ? op_vld_ff : res_vld_ff;
   assign op_vld_in  = req_ready ? req_valid : op_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_vld_ff  <= 1'b0;
         res_vld_ff <= 1'b0;
      end else begin
         op_vld_ff  <= op_vld_in;
         res_vld_ff <= res_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) op_ff <= req_data;
      if (adv && op_vld_ff) res_ff <= res_in;
   end

   assign rsp_valid = res_vld_ff;
   assign rsp_data  = res_ff;

endmodule

[design/psimd_checker.sv]
// Port-level checker for the SIMD ALU, bound to the top level
`include "assert_macros.svh"
module psimd_checker import psimd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, req_valid && req_ready && rsp_ready, ##1 rsp_valid)
   `ASSERT_IMPL(a_gen_hi_zero, clock, reset, rsp_valid && rsp_data.to_general_reg, rsp_data.result_hi == 64'd0 && rsp_data.result_lo[63:16] == 48'd0)
endmodule

bind packed_integer_simd_alu psimd_checker u_psimd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
